/* rtl/fau_pkg.sv */
package fau_pkg;

  // Command codes
  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_RED = 3'd4;

  localparam int NUM_W = 34;
  localparam int DEN_W = 33;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_COMB,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_DONE
  } state_t;

  // Request to the shared divider
  typedef struct packed {
    logic start;
  } div_ctl_t;

endpackage

/* rtl/fau_div.sv */
// Restoring divider, one quotient bit per cycle
module fau_div
  import fau_pkg::*;
#(
  parameter int W = 66
) (
  input  logic         clk,
  input  logic         rst,
  input  div_ctl_t     ctl,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output logic [W-1:0] remainder,
  output logic         done
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo;
  logic [W:0]    rem;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  assign shifted = {rem[W-1:0], quo[W-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !ctl.start && (cnt == CW'(1));
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        if (!diff[W]) begin
          rem <= diff;
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem[W-1:0];

endmodule

/* rtl/fraction_arithmetic_unit.sv */
// Sequence: three multiplies and a combine step, then one Euclid
// remainder step per divider result until the remainder is zero, then two
// divisions by the GCD, numerator first and denominator second, before
// out_valid. A zero result denominator goes straight to the result.
// Throughput: one request at a time, in_stall high until the result is
// taken. rst (synchronous, active high) returns the sequencer to idle.
module fraction_arithmetic_unit
  import fau_pkg::*;
#(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [2:0]               command,
  input  logic signed [15:0]       a_num,
  input  logic signed [15:0]       a_den,
  input  logic signed [15:0]       b_num,
  input  logic signed [15:0]       b_den,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [NUM_W-1:0]  res_num,
  output logic [DEN_W-1:0]         res_den,
  output logic                     zero_den_error
);

  localparam int OW = OPERAND_WIDTH;
  localparam int PW = 2 * OW;
  localparam int MW = PW + 2;

  state_t state, state_next;

  logic [2:0]    cmd;
  logic [OW-1:0] anm, adm, bnm, bdm;
  logic          ans, ads, bns, bds;
  logic [PW-1:0] p0, p1, p2;
  logic [MW-1:0] nm, dm, gx, gy;
  logic          nneg, dneg;

  div_ctl_t      dctl;
  logic [MW-1:0] d_a, d_b, d_q, d_r;
  logic          d_done;

  // Operand fields cut to OPERAND_WIDTH bits (magnitudes are taken in ST_IDLE)
  logic [OW-1:0] fa_n, fa_d, fb_n, fb_d;
  assign fa_n = OW'(a_num);
  assign fa_d = OW'(a_den);
  assign fb_n = OW'(b_num);
  assign fb_d = OW'(b_den);

  // Shared multiplier operands
  logic [OW-1:0] mx, my;
  logic [PW-1:0] mp;
  always_comb begin
    mx = anm;
    my = bdm;
    case (state)
      ST_MUL0: begin
        mx = adm;
        my = bdm;
        if (cmd == CMD_MUL) my = bdm;
      end
      ST_MUL1: begin
        mx = anm;
        my = (cmd == CMD_MUL) ? bnm : bdm;
        if (cmd == CMD_DIV) my = bdm;
      end
      ST_MUL2: begin
        mx = (cmd == CMD_DIV) ? adm : bnm;
        my = (cmd == CMD_DIV) ? bnm : adm;
      end
      default: ;
    endcase
  end
  assign mp = mx * my;

  fau_div #(.W(MW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (dctl),
    .dividend (d_a),
    .divisor  (d_b),
    .quotient (d_q),
    .remainder(d_r),
    .done     (d_done)
  );

  // Combine step (sign-magnitude)
  logic          addsub, same;
  logic          s1, s2;
  logic [MW-1:0] m1, m2, sm;
  logic          ss;
  always_comb begin
    addsub = (cmd == CMD_ADD) || (cmd == CMD_SUB);
    same = (adm == bdm) && ((ads == bds) || (adm == '0));
    if (same) begin
      m1 = MW'(anm);
      s1 = ans;
      m2 = MW'(bnm);
      s2 = bns;
    end else begin
      m1 = MW'(p1);
      s1 = ans ^ bds;
      m2 = MW'(p2);
      s2 = bns ^ ads;
    end
    if (cmd == CMD_SUB) s2 = ~s2;
    if (s1 == s2) begin
      sm = m1 + m2;
      ss = s1;
    end else if (m1 >= m2) begin
      sm = m1 - m2;
      ss = s1;
    end else begin
      sm = m2 - m1;
      ss = s2;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_MUL0;
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_COMB;
      ST_COMB: state_next = ST_GCD;
      ST_GCD: begin
        if (dm == '0) state_next = ST_DONE;
        else if (gy == '0) state_next = ST_DIVN;
        else if (d_done) state_next = ST_GCD;
      end
      ST_DIVN: if (d_done) state_next = ST_DIVD;
      ST_DIVD: if (d_done) state_next = ST_DONE;
      ST_DONE: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Divider requests
  logic gbusy;
  always_comb begin
    dctl.start = 1'b0;
    d_a = gx;
    d_b = gy;
    unique case (state)
      ST_GCD: dctl.start = (dm != '0) && (gy != '0) && !gbusy;
      ST_DIVN: begin
        d_a = nm;
        d_b = gx;
        dctl.start = !gbusy;
      end
      ST_DIVD: begin
        d_a = dm;
        d_b = gx;
        dctl.start = !gbusy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      gbusy <= 1'b0;
    end else begin
      state <= state_next;
      if (state != state_next) gbusy <= 1'b0;
      else if (dctl.start) gbusy <= 1'b1;
      else if (d_done) gbusy <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cmd <= command;
        ans <= fa_n[OW-1];
        ads <= fa_d[OW-1];
        bns <= fb_n[OW-1];
        bds <= fb_d[OW-1];
        anm <= fa_n[OW-1] ? (~fa_n + 1'b1) : fa_n;
        adm <= fa_d[OW-1] ? (~fa_d + 1'b1) : fa_d;
        bnm <= fb_n[OW-1] ? (~fb_n + 1'b1) : fb_n;
        bdm <= fb_d[OW-1] ? (~fb_d + 1'b1) : fb_d;
      end
      ST_MUL0: p0 <= mp;
      ST_MUL1: p1 <= mp;
      ST_MUL2: p2 <= mp;
      ST_COMB: begin
        if (addsub) begin
          nm <= sm;
          nneg <= ss;
          dm <= same ? MW'(adm) : MW'(p0);
          dneg <= same ? ads : (ads ^ bds);
        end else if (cmd == CMD_MUL) begin
          nm <= MW'(p1);
          nneg <= ans ^ bns;
          dm <= MW'(p0);
          dneg <= ads ^ bds;
        end else if (cmd == CMD_DIV) begin
          nm <= MW'(p1);
          nneg <= ans ^ bds;
          dm <= MW'(p2);
          dneg <= ads ^ bns;
        end else begin
          nm <= MW'(anm);
          nneg <= ans;
          dm <= MW'(adm);
          dneg <= ads;
        end
        gx <= addsub ? sm : ((cmd == CMD_MUL) || (cmd == CMD_DIV)) ? MW'(p1) : MW'(anm);
        gy <= addsub ? (same ? MW'(adm) : MW'(p0))
                     : (cmd == CMD_DIV) ? MW'(p2)
                     : (cmd == CMD_MUL) ? MW'(p0) : MW'(adm);
      end
      ST_GCD: if (d_done) begin
        gx <= gy;
        gy <= d_r;
      end
      ST_DIVN: if (d_done) nm <= d_q;
      ST_DIVD: if (d_done) dm <= d_q;
      default: ;
    endcase
  end

  // Outputs
  logic          oneg;
  logic [MW-1:0] osn;
  always_comb begin
    in_stall = (state != ST_IDLE);
    out_valid = (state == ST_DONE);
    zero_den_error = (dm == '0);
    oneg = zero_den_error ? nneg : (nneg ^ dneg);
    oneg = oneg && (nm != '0);
    osn = oneg ? (~nm + 1'b1) : nm;
    res_num = NUM_W'(osn);
    res_den = DEN_W'(dm);
  end

endmodule

/* tb/sv/fraction_arithmetic_unit_test.sv */
`timescale 1ns / 1ps

module fraction_arithmetic_unit_test
  import fau_pkg::*;
();

  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] an;
    logic [15:0] ad;
    logic [15:0] bn;
    logic [15:0] bd;
  } frac_req_t;

  typedef struct {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             err;
  } frac_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] command = '0;
  logic signed [15:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [NUM_W-1:0] res_num;
  logic [DEN_W-1:0] res_den;
  logic zero_den_error;

  frac_req_t pending_reqs[$];
  frac_res_t expected_fracs[$];
  int errors = 0;
  int results_seen = 0;
  int sent = 0;
  bit hold_sender = 1'b0;

  fraction_arithmetic_unit uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Signed 16-bit operand to sign and magnitude
  function automatic void split(input logic [15:0] v, output bit neg,
                                output logic [63:0] mag);
    logic [15:0] nv;
    neg = v[15];
    nv = ~v + 16'd1;
    mag = neg ? {48'd0, nv} : {48'd0, v};
  endfunction

  function automatic void sm_addv(input bit xn, input logic [63:0] xm, input bit yn,
                                  input logic [63:0] ym, output bit rn,
                                  output logic [63:0] rm);
    if (xn == yn) begin
      rm = xm + ym; rn = xn;
    end else if (xm >= ym) begin
      rm = xm - ym; rn = xn;
    end else begin
      rm = ym - xm; rn = yn;
    end
    if (rm == 0) rn = 1'b0;
  endfunction

  function automatic frac_res_t reduce_fraction(input frac_req_t r);
    frac_res_t o;
    bit ann, adn, bnn, bdn, nn, dn, t1n, t2n, neg;
    logic [63:0] anm, adm, bnm, bdm, nm, dm, t1m, t2m, x, y, t;
    split(r.an, ann, anm);
    split(r.ad, adn, adm);
    split(r.bn, bnn, bnm);
    split(r.bd, bdn, bdm);
    case (r.cmd)
      CMD_ADD, CMD_SUB: begin
        if (r.cmd == CMD_SUB && bnm != 0) bnn = !bnn;
        if (adm == bdm && (adn == bdn || adm == 0)) begin
          dn = adn; dm = adm;
          sm_addv(ann, anm, bnn, bnm, nn, nm);
        end else begin
          dm = adm * bdm; dn = (adn != bdn) && dm != 0;
          t1m = anm * bdm; t1n = (ann != bdn) && t1m != 0;
          t2m = bnm * adm; t2n = (bnn != adn) && t2m != 0;
          sm_addv(t1n, t1m, t2n, t2m, nn, nm);
        end
      end
      CMD_MUL: begin
        nm = anm * bnm; nn = (ann != bnn) && nm != 0;
        dm = adm * bdm; dn = (adn != bdn) && dm != 0;
      end
      CMD_DIV: begin
        nm = anm * bdm; nn = (ann != bdn) && nm != 0;
        dm = adm * bnm; dn = (adn != bnn) && dm != 0;
      end
      default: begin
        nm = anm; nn = ann; dm = adm; dn = adn;
      end
    endcase
    if (dm == 0) begin
      neg = nn && nm != 0;
      o.num = neg ? NUM_W'(-nm) : NUM_W'(nm);
      o.den = '0;
      o.err = 1'b1;
    end else begin
      x = nm; y = dm;
      while (y != 0) begin
        t = x % y; x = y; y = t;
      end
      nm = nm / x; dm = dm / x;
      neg = (nn != dn) && nm != 0;
      o.num = neg ? NUM_W'(-nm) : NUM_W'(nm);
      o.den = DEN_W'(dm);
      o.err = 1'b0;
    end
    return o;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("MISMATCH %s: got %0h want %0h", what, got, want);
  endtask

  // Stall seen at the last rising edge decides acceptance
  logic in_stall_q = 1'b1;
  always @(posedge clk) begin
    in_stall_q <= in_stall;
  end

  // Driver: one request per gap, inputs change on the falling edge
  int in_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall_q) begin
        in_valid <= 1'b0;
        in_gap = $urandom_range(0, 8);
      end else if (!in_valid) begin
        if (in_gap > 0) in_gap--;
        else if (!hold_sender && pending_reqs.size() > 0) begin
          frac_req_t r;
          r = pending_reqs.pop_front();
          command <= r.cmd; a_num <= r.an; a_den <= r.ad;
          b_num <= r.bn; b_den <= r.bd;
          in_valid <= 1'b1;
          expected_fracs.push_back(reduce_fraction(r));
          sent++;
        end
      end
    end
  end

  // Receiver stall: random wait per result
  int out_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      frac_res_t w;
      results_seen++;
      out_gap = $urandom_range(0, 8);
      if (expected_fracs.size() == 0) begin
        report("unexpected result", 64'(res_num), 64'd0);
      end else begin
        w = expected_fracs.pop_front();
        if (res_num !== w.num) report("res_num", 64'(res_num), 64'(w.num));
        if (res_den !== w.den) report("res_den", 64'(res_den), 64'(w.den));
        if (zero_den_error !== w.err)
          report("zero_den_error", 64'(zero_den_error), 64'(w.err));
      end
    end
  end

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 4)) - 16'd2;
      1: return 16'($urandom_range(0, 40)) - 16'd20;
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_req(input logic [2:0] c, input logic [15:0] an, input logic [15:0] ad,
                         input logic [15:0] bn, input logic [15:0] bd);
    frac_req_t r;
    r.cmd = c; r.an = an; r.ad = ad; r.bn = bn; r.bd = bd;
    pending_reqs.push_back(r);
  endtask

  initial begin
    int k;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // Directed: every command, extremes, zero denominators, shared denominators
    add_req(CMD_ADD, 16'd1, 16'd2, 16'd1, 16'd2);
    add_req(CMD_ADD, 16'd1, 16'd3, 16'd1, 16'd6);
    add_req(CMD_SUB, 16'd1, 16'd2, 16'd1, 16'd2);
    add_req(CMD_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    add_req(CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_req(CMD_MUL, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    add_req(CMD_DIV, 16'd3, 16'd4, 16'd0, 16'd5);
    add_req(CMD_DIV, -16'sd6, 16'd4, 16'd9, -16'sd8);
    add_req(CMD_RED, 16'd12, -16'sd8, 16'd0, 16'd0);
    add_req(CMD_RED, 16'd0, 16'd0, 16'd0, 16'd0);
    add_req(CMD_RED, -16'sd5, 16'd0, 16'd0, 16'd0);
    add_req(CMD_RED, 16'd0, -16'sd7, 16'd0, 16'd0);
    add_req(3'd5, 16'd8, 16'd4, 16'hffff, 16'hffff);
    add_req(3'd6, 16'hffff, 16'hffff, 16'd1, 16'd1);
    add_req(3'd7, 16'h8000, 16'h8000, 16'd1, 16'd1);
    add_req(CMD_ADD, 16'd5, 16'd0, 16'd3, 16'd0);
    add_req(CMD_ADD, 16'd0, 16'd7, 16'd0, -16'sd7);
    add_req(CMD_SUB, 16'h7fff, 16'd1, 16'h8000, 16'd1);
    add_req(CMD_MUL, 16'd0, 16'd3, 16'd5, 16'd0);
    add_req(CMD_ADD, 16'd4, -16'sd6, 16'd2, -16'sd6);
    for (k = 0; k < 1500; k++) begin
      logic [15:0] ad;
      ad = pick16();
      add_req(3'($urandom_range(0, 7)), pick16(), ad, pick16(),
              $urandom_range(0, 3) == 0 ? ad : pick16());
      if (k == 700) begin
        wait (pending_reqs.size() == 0);
        hold_sender = 1'b1;
        wait (expected_fracs.size() == 0 && !in_valid);
        repeat (20) @(posedge clk);
        hold_sender = 1'b0;
      end
    end
    wait (pending_reqs.size() == 0 && !in_valid && expected_fracs.size() == 0);
    repeat (1000) @(posedge clk);
    $display("Covered %0d requests over all commands, %0d results checked", sent,
             results_seen);
    if (errors == 0 && expected_fracs.size() == 0) begin
      $display("fraction_arithmetic_unit verification clean");
    end else begin
      $display("fraction_arithmetic_unit verification failed");
    end
    $finish;
  end

  initial begin
    #150ms;
    $display("fraction_arithmetic_unit verification failed");
    $finish;
  end

endmodule
